// File: src/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// shared widths, reset values and result word layout for the median monitor
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int OUT_COUNT_W = 32;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(100);

    typedef enum logic [1:0] {
        QUAL_EXCELLENT = 2'd0,
        QUAL_GOOD      = 2'd1,
        QUAL_FAIR      = 2'd2,
        QUAL_POOR      = 2'd3
    } quality_t;

    // packed msb first, so median_value lands in the low bits
    typedef struct packed {
        logic [OUT_COUNT_W-1:0] sample_total;
        logic [OUT_COUNT_W-1:0] noise_total;
        quality_t               quality_class;
        logic                   noise_flag;
        logic [SAMPLE_W-1:0]    median_value;
    } result_t;

endpackage

// File: src/smm_cell.sv
// ----------------------------------------------------------------------------
// smm_cell
// one slot of the sorted window: drops the expiring entry and takes in the
// new sample, using only its own and its two neighbors' entries
// ----------------------------------------------------------------------------
module smm_cell #(
    parameter int               TAG_W   = 3,
    parameter logic [TAG_W-1:0] IDX_TAG = '0,
    parameter bit               FIRST   = 1'b0,
    parameter bit               LAST    = 1'b0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic [smm_pkg::SAMPLE_W-1:0]  sample,
    input  logic [TAG_W-1:0]              slot,
    input  logic [smm_pkg::SAMPLE_W-1:0]  left_val,
    input  logic [TAG_W-1:0]              left_tag,
    input  logic                          left_past,
    input  logic [smm_pkg::SAMPLE_W-1:0]  right_val,
    input  logic [TAG_W-1:0]              right_tag,
    output logic                          past_out,
    output logic [smm_pkg::SAMPLE_W-1:0]  val,
    output logic [TAG_W-1:0]              tag
);
    import smm_pkg::*;

    logic [SAMPLE_W-1:0] val_reg, val_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic                past;
    logic                cur_none;
    logic [SAMPLE_W-1:0] cur_val, prev_val;
    logic [TAG_W-1:0]    cur_tag, prev_tag;
    logic                gt_cur, gt_prev;

    // past: the expiring entry sits at this cell or to its left
    assign past     = (tag_reg == slot) || left_past;
    assign past_out = past;

    // entry at this place once the expiring one is removed
    assign cur_none = past && LAST;
    assign cur_val  = (past && !LAST) ? right_val : val_reg;
    assign cur_tag  = (past && !LAST) ? right_tag : tag_reg;
    // same for the place on the left
    assign prev_val = left_past ? val_reg : left_val;
    assign prev_tag = left_past ? tag_reg : left_tag;

    assign gt_cur  = cur_none || (cur_val > sample);
    assign gt_prev = prev_val > sample;

    always_comb begin
        if (!gt_cur) begin
            val_next = cur_val;
            tag_next = cur_tag;
        end else if (FIRST || !gt_prev) begin
            val_next = sample;
            tag_next = slot;
        end else begin
            val_next = prev_val;
            tag_next = prev_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
            tag_reg <= IDX_TAG;
        end else if (load) begin
            val_reg <= val_next;
            tag_reg <= tag_next;
        end
    end

    assign val = val_reg;
    assign tag = tag_reg;

endmodule

// File: src/smm_stats.sv
// ----------------------------------------------------------------------------
// smm_stats
// noise decision, saturating counters, quality class and output register
// ----------------------------------------------------------------------------
module smm_stats #(
    parameter int COUNT_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [smm_pkg::SAMPLE_W-1:0]  sample,
    input  logic [smm_pkg::SAMPLE_W-1:0]  median,
    input  logic [smm_pkg::SAMPLE_W-1:0]  threshold,
    input  logic                          out_ready,
    output logic                          advance,
    output logic                          out_valid,
    output smm_pkg::result_t              result
);
    import smm_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  eval_valid_reg, eval_valid_next;
    logic [SAMPLE_W-1:0]   eval_median_reg;
    logic                  eval_flag_reg;
    logic [COUNT_BITS-1:0] noise_cnt_reg, noise_cnt_next;
    logic [COUNT_BITS-1:0] sample_cnt_reg, sample_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               result_reg;

    logic [SAMPLE_W-1:0]   abs_diff;
    logic                  flag;
    logic [COUNT_BITS+2:0] noise_x5;
    logic [COUNT_BITS+4:0] noise_x20, noise_x10, noise_x5w, total_w;
    quality_t              quality;

    assign advance = !out_valid_reg || out_ready;

    // distance from the median
    assign abs_diff = (sample >= median) ? (sample - median) : (median - sample);
    assign flag     = abs_diff > threshold;

    always_comb begin
        sample_cnt_next = sample_cnt_reg;
        noise_cnt_next  = noise_cnt_reg;
        if (in_valid) begin
            if (sample_cnt_reg != COUNT_MAX) begin
                sample_cnt_next = sample_cnt_reg + 1'b1;
            end
            if (flag && noise_cnt_reg != COUNT_MAX) begin
                noise_cnt_next = noise_cnt_reg + 1'b1;
            end
        end
    end

    assign eval_valid_next = in_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_valid_reg <= 1'b0;
            noise_cnt_reg  <= '0;
            sample_cnt_reg <= '0;
        end else if (advance) begin
            eval_valid_reg <= eval_valid_next;
            noise_cnt_reg  <= noise_cnt_next;
            sample_cnt_reg <= sample_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            eval_median_reg <= median;
            eval_flag_reg   <= flag;
        end
    end

    // quality from the counters of the item in the eval stage
    assign noise_x5  = {noise_cnt_reg, 2'b00} + (COUNT_BITS+3)'(noise_cnt_reg);
    assign noise_x5w = (COUNT_BITS+5)'(noise_x5);
    assign noise_x10 = {noise_x5w[COUNT_BITS+3:0], 1'b0};
    assign noise_x20 = {noise_x5w[COUNT_BITS+2:0], 2'b00};
    assign total_w   = (COUNT_BITS+5)'(sample_cnt_reg);

    always_comb begin
        if (noise_x20 < total_w) begin
            quality = QUAL_EXCELLENT;
        end else if (noise_x10 < total_w) begin
            quality = QUAL_GOOD;
        end else if (noise_x5w < total_w) begin
            quality = QUAL_FAIR;
        end else begin
            quality = QUAL_POOR;
        end
    end

    assign out_valid_next = eval_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && eval_valid_reg) begin
            result_reg.median_value  <= eval_median_reg;
            result_reg.noise_flag    <= eval_flag_reg;
            result_reg.quality_class <= quality;
            result_reg.noise_total   <= OUT_COUNT_W'(noise_cnt_reg);
            result_reg.sample_total  <= OUT_COUNT_W'(sample_cnt_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_noise_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        noise_cnt_reg <= sample_cnt_reg)
        else $error("noise count above sample count");

    a_count_moves_on_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(sample_cnt_reg) |-> $past(advance && in_valid))
        else $error("sample count moved without an item");

endmodule

// File: src/sliding_median_noise_monitor.sv
// ----------------------------------------------------------------------------
// sliding_median_noise_monitor
// running median of a sample window kept sorted in a row of cells, with an
// impulse noise flag, saturating counters and a quality class per sample
//
//   channel  dir  handshake          payload
//   s_       in   tvalid/tready      tdata[11:0] sample
//   m_       out  tvalid/tready      tdata[78:0] result word
//   cfg_     in   cfg_we             cfg_wdata noise_threshold
//
// one word per cycle sustained while the output is not stalled; input, eval and output registers in turn
// the cell row re-sorts the window in the accept cycle, counters follow
// reset clears the window to zeros, counters to zero, threshold to 100
// a stalled output holds the whole pipe, s_tready drops with it
// ----------------------------------------------------------------------------
module sliding_median_noise_monitor #(
    parameter int WINDOW_LENGTH = 5,
    parameter int COUNT_BITS    = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // [11:0] sample
    input  logic [15:0]                  s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [11:0] median_value, [12] noise_flag, [14:13] quality_class,
    // [46:15] noise_total, [78:47] sample_total
    output logic [79:0]                  m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         cfg_we,
    input  logic [smm_pkg::SAMPLE_W-1:0] cfg_wdata
);
    import smm_pkg::*;

    localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int MID    = WINDOW_LENGTH / 2;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LENGTH - 1);

    logic [SAMPLE_W-1:0] threshold_reg;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                accept;
    logic                advance;
    result_t             result;

    logic [SAMPLE_W-1:0] cell_val  [WINDOW_LENGTH];
    logic [SLOT_W-1:0]   cell_tag  [WINDOW_LENGTH];
    logic                cell_past [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] slot_hit;
    logic [WINDOW_LENGTH-1:0] in_order;

    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            threshold_reg <= cfg_wdata;
        end
    end

    assign slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= accept;
            if (accept) begin
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
        localparam int L = (i == 0) ? 0 : i - 1;
        localparam int R = (i == WINDOW_LENGTH - 1) ? i : i + 1;

        smm_cell #(
            .TAG_W   (SLOT_W),
            .IDX_TAG (SLOT_W'(i)),
            .FIRST   (i == 0),
            .LAST    (i == WINDOW_LENGTH - 1)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (accept),
            .sample    (s_tdata[SAMPLE_W-1:0]),
            .slot      (slot_reg),
            .left_val  (cell_val[L]),
            .left_tag  (cell_tag[L]),
            .left_past ((i == 0) ? 1'b0 : cell_past[L]),
            .right_val (cell_val[R]),
            .right_tag (cell_tag[R]),
            .past_out  (cell_past[i]),
            .val       (cell_val[i]),
            .tag       (cell_tag[i])
        );

        assign slot_hit[i] = cell_tag[i] == slot_reg;
        assign in_order[i] = (i == WINDOW_LENGTH - 1) || (cell_val[i] <= cell_val[R]);
    end

    smm_stats #(
        .COUNT_BITS (COUNT_BITS)
    ) u_stats (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .sample    (in_sample_reg),
        .median    (cell_val[MID]),
        .threshold (threshold_reg),
        .out_ready (m_tready),
        .advance   (advance),
        .out_valid (m_tvalid),
        .result    (result)
    );

    assign m_tdata = {1'b0, result};

    a_window_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        &in_order)
        else $error("cell row out of order");

    a_one_expiring: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(slot_hit))
        else $error("expiring slot not held by exactly one cell");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_LAST)
        else $error("write slot beyond window");

endmodule
